// ----- sv/rfp_pkg.sv -----
`timescale 1ns / 1ps

package rfp_pkg;

  localparam int FRAME_BYTES = 11;
  localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
  localparam int INDEX_W = $clog2(FRAME_BYTES);
  localparam int DIST_W = 20;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef enum logic [1:0] {
    STATUS_REJECT   = 2'd0,
    STATUS_DISTANCE = 2'd1,
    STATUS_DEVICE   = 2'd2,
    STATUS_BAD_DIGIT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FAULT_NONE        = 3'd0,
    FAULT_BATTERY     = 3'd1,
    FAULT_CALCULATION = 3'd2,
    FAULT_RANGE       = 3'd3,
    FAULT_WEAK_SIGNAL = 3'd4,
    FAULT_STRONG_LIGHT = 3'd5,
    FAULT_DISPLAY     = 3'd6,
    FAULT_UNKNOWN     = 3'd7
  } fault_t;

  typedef struct packed {
    status_t            status;
    fault_t             fault_kind;
    logic [DIST_W-1:0]  distance;
  } result_t;

  localparam logic [7:0] HDR_BYTE0 = 8'h80;
  localparam logic [7:0] HDR_BYTE1 = 8'h06;
  localparam logic [7:0] HDR_BYTE2 = 8'h83;
  localparam logic [7:0] ASCII_E = 8'h45;
  localparam logic [7:0] ASCII_R = 8'h52;
  localparam logic [7:0] ASCII_0 = 8'h30;
  localparam logic [7:0] ASCII_1 = 8'h31;
  localparam logic [7:0] ASCII_2 = 8'h32;
  localparam logic [7:0] ASCII_4 = 8'h34;
  localparam logic [7:0] ASCII_5 = 8'h35;
  localparam logic [7:0] ASCII_6 = 8'h36;
  localparam logic [7:0] ASCII_8 = 8'h38;
  localparam logic [7:0] ASCII_9 = 8'h39;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_IDLE = 1'b1;

endpackage

// ----- sv/rfp_frame_store.sv -----
`timescale 1ns / 1ps

module rfp_frame_store (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [7:0]     wr_byte,
  input  logic           clr,
  output rfp_pkg::frame_t frame
);

  logic [rfp_pkg::COUNT_W-1:0] byte_count;
  rfp_pkg::frame_t              store;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      store <= '0;
      byte_count <= '0;
    end else if (wr_en && (byte_count < rfp_pkg::COUNT_W'(rfp_pkg::FRAME_BYTES))) begin
      store[byte_count[rfp_pkg::INDEX_W-1:0]] <= wr_byte;
      byte_count <= byte_count + 1'b1;
    end
  end

  assign frame = store;

endmodule

// ----- sv/rfp_judge.sv -----
`timescale 1ns / 1ps

module rfp_judge (
  input  rfp_pkg::frame_t  frame,
  output rfp_pkg::result_t result
);

  localparam int DW = rfp_pkg::DIST_W;

  logic [7:0]    sum;
  logic          header_ok;
  logic          check_ok;
  logic          is_err;
  logic          digits_ok;
  logic [3:0]    d3, d4, d5, d7, d8;
  rfp_pkg::fault_t fault;
  logic [DW-1:0] range_value;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= rfp_pkg::ASCII_0) && (b <= rfp_pkg::ASCII_9);
  endfunction

  always_comb begin
    sum = '0;
    for (int i = 0; i < 10; i++) begin
      sum = sum + frame[i];
    end
  end

  assign header_ok = (frame[0] == rfp_pkg::HDR_BYTE0) && (frame[1] == rfp_pkg::HDR_BYTE1) &&
                     (frame[2] == rfp_pkg::HDR_BYTE2);
  assign check_ok  = (8'(sum + frame[10]) == 8'd0);
  assign is_err    = (frame[3] == rfp_pkg::ASCII_E) && (frame[4] == rfp_pkg::ASCII_R) &&
                     (frame[5] == rfp_pkg::ASCII_R);
  assign digits_ok = is_digit(frame[3]) && is_digit(frame[4]) && is_digit(frame[5]) &&
                     is_digit(frame[7]) && is_digit(frame[8]);

  assign d3 = frame[3][3:0];
  assign d4 = frame[4][3:0];
  assign d5 = frame[5][3:0];
  assign d7 = frame[7][3:0];
  assign d8 = frame[8][3:0];

  assign range_value = DW'(DW'(d3) * DW'(100000)) + DW'(DW'(d4) * DW'(10000)) +
                       DW'(DW'(d5) * DW'(1000)) + DW'(DW'(d7) * DW'(100)) +
                       DW'(DW'(d8) * DW'(10));

  always_comb begin
    fault = rfp_pkg::FAULT_UNKNOWN;
    if (frame[8] == rfp_pkg::ASCII_1) begin
      case (frame[9])
        rfp_pkg::ASCII_0: fault = rfp_pkg::FAULT_BATTERY;
        rfp_pkg::ASCII_4: fault = rfp_pkg::FAULT_CALCULATION;
        rfp_pkg::ASCII_5: fault = rfp_pkg::FAULT_RANGE;
        rfp_pkg::ASCII_6: fault = rfp_pkg::FAULT_WEAK_SIGNAL;
        rfp_pkg::ASCII_8: fault = rfp_pkg::FAULT_STRONG_LIGHT;
        default:          fault = rfp_pkg::FAULT_UNKNOWN;
      endcase
    end else if ((frame[8] == rfp_pkg::ASCII_2) && (frame[9] == rfp_pkg::ASCII_6)) begin
      fault = rfp_pkg::FAULT_DISPLAY;
    end
  end

  always_comb begin
    result.status = rfp_pkg::STATUS_REJECT;
    result.fault_kind = rfp_pkg::FAULT_NONE;
    result.distance = '0;
    if (header_ok && check_ok) begin
      if (is_err) begin
        result.status = rfp_pkg::STATUS_DEVICE;
        result.fault_kind = fault;
      end else if (!digits_ok) begin
        result.status = rfp_pkg::STATUS_BAD_DIGIT;
      end else begin
        result.status = rfp_pkg::STATUS_DISTANCE;
        result.distance = range_value;
      end
    end
  end

endmodule

// ----- sv/rangefinder_reply_frame_parser_unit.sv -----
`timescale 1ns / 1ps

// Parses reply frames of a laser rangefinder. Each slave-side transfer is either a received
// byte (tuser low) or a line-idle event (tuser high). The first 11 bytes of a frame are
// kept and later ones are dropped; an idle event judges the frame (header 80 06 83 and a
// two's-complement checksum in byte 10), produces exactly one master-side transfer with
// the status, fault kind and distance, and clears the frame. The block takes one transfer
// every cycle unless an idle event waits in the input register for an unaccepted result;
// an idle event passes the input register, the combinational judge and the result register.
module rangefinder_reply_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [2:0] fault_kind, [22:3] distance, [23] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  logic             in_valid;
  logic             in_op;
  logic [7:0]       in_byte;
  logic             out_valid;
  rfp_pkg::result_t out_result;
  rfp_pkg::result_t judged;
  rfp_pkg::frame_t  frame;
  logic             slot_free;
  logic             proc;

  assign slot_free = !out_valid || m_axis_tready;
  assign proc = in_valid && ((in_op == rfp_pkg::OP_DATA) || slot_free);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  rfp_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (proc && (in_op == rfp_pkg::OP_DATA)),
    .wr_byte (in_byte),
    .clr     (proc && (in_op == rfp_pkg::OP_IDLE)),
    .frame   (frame)
  );

  rfp_judge u_judge (
    .frame  (frame),
    .result (judged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && (in_op == rfp_pkg::OP_IDLE)) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && (in_op == rfp_pkg::OP_IDLE)) begin
      out_result <= judged;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {1'b0, out_result.distance, out_result.fault_kind};
  assign m_axis_tuser = out_result.status;

endmodule
